@@ hdl/fcbs_pkg.sv @@
// Shared types and constants for the frustum cull block.
// Plane register layout, per-plane product record and the normal-magnitude helper.
// No dependencies.
`default_nettype none

package fcbs_pkg;

    // Register file geometry
    localparam int REG_COUNT = 6;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int IDX_LSB   = 3;
    localparam int IDX_W     = ADDR_W - IDX_LSB;

    // Field widths
    localparam int COEF_W     = 12;
    localparam int OFS_W      = 28;
    localparam int POS_W      = 16;
    localparam int EXT_W      = 15;
    localparam int NSUM_W     = 13;
    localparam int PROD_W     = 28;
    localparam int ACC_W      = 32;
    localparam int FRAC_SHIFT = 10;

    typedef logic [IDX_W-1:0] reg_idx_t;

    // Packed plane register: offset on top, then normal z, y, x
    typedef struct packed {
        logic signed [OFS_W-1:0]  d;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] a;
    } plane_t;

    // Registered products for one plane; bias is the cube reach or scaled radius
    typedef struct packed {
        logic signed [PROD_W-1:0] ax;
        logic signed [PROD_W-1:0] by;
        logic signed [PROD_W-1:0] cz;
        logic        [PROD_W-1:0] bias;
    } plane_prod_t;

    // |a| + |b| + |c| of a plane normal
    function automatic logic [NSUM_W-1:0] norm_sum(input plane_t p);
        logic [COEF_W-1:0] ma;
        logic [COEF_W-1:0] mb;
        logic [COEF_W-1:0] mc;
        ma = p.a[COEF_W-1] ? COEF_W'(-p.a) : COEF_W'(p.a);
        mb = p.b[COEF_W-1] ? COEF_W'(-p.b) : COEF_W'(p.b);
        mc = p.c[COEF_W-1] ? COEF_W'(-p.c) : COEF_W'(p.c);
        return NSUM_W'(ma) + NSUM_W'(mb) + NSUM_W'(mc);
    endfunction

endpackage

`default_nettype wire

@@ hdl/frustum_cull_box_sphere.sv @@
// Frustum cull for axis-aligned cubes and spheres against up to six planes.
// A request passes through the input register, the product register and the result
// register in order. Throughput: one request per cycle; each stage holds when the
// next one is full and not advancing.
// Reset clears all stage valids and sets every plane register to zero.
`default_nettype none

module frustum_cull_box_sphere #(
    parameter int NUM_PLANES = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic signed [fcbs_pkg::POS_W-1:0]   center_x,
    input  logic signed [fcbs_pkg::POS_W-1:0]   center_y,
    input  logic signed [fcbs_pkg::POS_W-1:0]   center_z,
    input  logic [fcbs_pkg::EXT_W-1:0]          extent,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                visible,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fcbs_pkg::ADDR_W-1:0]         paddr,
    input  logic [fcbs_pkg::DATA_W-1:0]         pwdata,
    output logic [fcbs_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import fcbs_pkg::*;

    // Planes beyond the register file are not tested and never reject
    localparam int TESTED = (NUM_PLANES < REG_COUNT) ? NUM_PLANES : REG_COUNT;

    plane_t [REG_COUNT-1:0]             planes;
    logic [REG_COUNT-1:0][NSUM_W-1:0]   nsums;
    plane_prod_t [TESTED-1:0]           prods;
    logic                               m_valid;
    logic                               m_ready;

    assign pready = 1'b1;

    fcbs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .planes  (planes),
        .nsums   (nsums)
    );

    fcbs_mult #(
        .TESTED (TESTED)
    ) u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z),
        .extent   (extent),
        .planes   (planes),
        .nsums    (nsums),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .prods    (prods)
    );

    fcbs_eval #(
        .TESTED (TESTED)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .prods     (prods),
        .planes    (planes),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .visible   (visible)
    );

endmodule

`default_nettype wire

@@ hdl/fcbs_regs.sv @@
// Plane register file behind the APB-style configuration port.
// Also keeps the normal magnitude sum of each plane, updated on write.
// Depends on fcbs_pkg.
`default_nettype none

module fcbs_regs (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [fcbs_pkg::ADDR_W-1:0]                 paddr,
    input  logic [fcbs_pkg::DATA_W-1:0]                 pwdata,
    output logic [fcbs_pkg::DATA_W-1:0]                 prdata,
    output fcbs_pkg::plane_t [fcbs_pkg::REG_COUNT-1:0]  planes,
    output logic [fcbs_pkg::REG_COUNT-1:0][fcbs_pkg::NSUM_W-1:0] nsums
);
    import fcbs_pkg::*;

    plane_t [REG_COUNT-1:0]             plane_reg;
    logic [REG_COUNT-1:0][NSUM_W-1:0]   nsum_reg;
    reg_idx_t                           idx;
    logic                               idx_ok;
    logic                               wr_en;

    // Decode the register slot; slots past the last plane are ignored
    assign idx    = paddr[ADDR_W-1:IDX_LSB];
    assign idx_ok = (idx < IDX_W'(REG_COUNT));
    assign wr_en  = psel & penable & pwrite & idx_ok;

    // Write plane and its normal magnitude sum together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            nsum_reg  <= '0;
        end
        else if (wr_en)
        begin
            plane_reg[idx] <= plane_t'(pwdata);
            nsum_reg[idx]  <= norm_sum(plane_t'(pwdata));
        end
    end

    // Read back the addressed plane
    assign prdata = idx_ok ? DATA_W'(plane_reg[idx]) : '0;
    assign planes = plane_reg;
    assign nsums  = nsum_reg;

endmodule

`default_nettype wire

@@ hdl/fcbs_mult.sv @@
// Input register and product stage of the cull pipeline.
// Registers the request, then forms a*x, b*y, c*z and the bias term per plane.
// Depends on fcbs_pkg.
`default_nettype none

module fcbs_mult #(
    parameter int TESTED = 6
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic                                        command,
    input  logic signed [fcbs_pkg::POS_W-1:0]           center_x,
    input  logic signed [fcbs_pkg::POS_W-1:0]           center_y,
    input  logic signed [fcbs_pkg::POS_W-1:0]           center_z,
    input  logic [fcbs_pkg::EXT_W-1:0]                  extent,
    input  fcbs_pkg::plane_t [fcbs_pkg::REG_COUNT-1:0]  planes,
    input  logic [fcbs_pkg::REG_COUNT-1:0][fcbs_pkg::NSUM_W-1:0] nsums,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output fcbs_pkg::plane_prod_t [TESTED-1:0]          prods
);
    import fcbs_pkg::*;

    logic                       s0_valid_reg;
    logic                       cmd_reg;
    logic signed [POS_W-1:0]    x_reg;
    logic signed [POS_W-1:0]    y_reg;
    logic signed [POS_W-1:0]    z_reg;
    logic [EXT_W-1:0]           ext_reg;
    logic                       s1_valid_reg;
    plane_prod_t [TESTED-1:0]   prod_reg;
    plane_prod_t [TESTED-1:0]   prod_next;
    logic                       s0_adv;
    logic                       s1_adv;

    // Each stage moves when it is empty or its successor takes it
    assign s1_adv   = !s1_valid_reg || m_ready;
    assign s0_adv   = !s0_valid_reg || s1_adv;
    assign in_ready = s0_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_adv)
                s0_valid_reg <= in_valid;
            if (s1_adv)
                s1_valid_reg <= s0_valid_reg;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (s0_adv && in_valid)
        begin
            cmd_reg <= command;
            x_reg   <= center_x;
            y_reg   <= center_y;
            z_reg   <= center_z;
            ext_reg <= extent;
        end
    end

    // Per-plane products; sphere uses the radius at distance scale
    always_comb
    begin
        for (int p = 0; p < TESTED; p++)
        begin
            prod_next[p].ax = planes[p].a * x_reg;
            prod_next[p].by = planes[p].b * y_reg;
            prod_next[p].cz = planes[p].c * z_reg;
            if (cmd_reg)
                prod_next[p].bias = PROD_W'({ext_reg, FRAC_SHIFT'(0)});
            else
                prod_next[p].bias = PROD_W'(ext_reg) * PROD_W'(nsums[p]);
        end
    end

    // Hold products until the evaluate stage takes them
    always_ff @(posedge clk)
    begin
        if (s1_adv && s0_valid_reg)
            prod_reg <= prod_next;
    end

    assign m_valid = s1_valid_reg;
    assign prods   = prod_reg;

endmodule

`default_nettype wire

@@ hdl/fcbs_eval.sv @@
// Evaluate stage of the cull pipeline.
// Sums products, offset and bias per plane and drops the volume on any negative sum.
// Depends on fcbs_pkg.
`default_nettype none

module fcbs_eval #(
    parameter int TESTED = 6
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        m_valid,
    output logic                                        m_ready,
    input  fcbs_pkg::plane_prod_t [TESTED-1:0]          prods,
    input  fcbs_pkg::plane_t [fcbs_pkg::REG_COUNT-1:0]  planes,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic                                        visible
);
    import fcbs_pkg::*;

    logic                       out_valid_reg;
    logic                       vis_reg;
    logic                       vis_next;
    logic [TESTED-1:0]          keep;
    logic signed [ACC_W-1:0]    acc [TESTED];
    logic                       adv;

    assign adv     = !out_valid_reg || out_ready;
    assign m_ready = adv;

    // Reach of the volume toward each plane; negative means rejected
    always_comb
    begin
        for (int p = 0; p < TESTED; p++)
        begin
            acc[p] = ACC_W'(prods[p].ax) + ACC_W'(prods[p].by) + ACC_W'(prods[p].cz)
                   + ACC_W'(planes[p].d) + ACC_W'(prods[p].bias);
            keep[p] = !acc[p][ACC_W-1];
        end
        vis_next = &keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= m_valid;
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (adv && m_valid)
            vis_reg <= vis_next;
    end

    assign out_valid = out_valid_reg;
    assign visible   = vis_reg;

endmodule

`default_nettype wire

@@ hdl/fcbs_checker.sv @@
// Port-level checks for the frustum cull block, bound to the top level.
// Covers reset, stall behavior, request intake and pipeline latency.
// Depends only on the top-level ports.
`default_nettype none

module fcbs_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  logic out_valid,
    input  logic out_ready,
    input  logic visible
);

    // No result is shown after an edge that sees reset held
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // A stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(visible))
        else $error("stalled result changed");

    // With the output free to move, a request is always taken
    a_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("request refused with free output");

    // A taken request's result becomes valid when the output stays ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind frustum_cull_box_sphere fcbs_checker u_fcbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .visible   (visible)
);

`default_nettype wire

@@ sim/tb_frustum_cull_box_sphere.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for frustum_cull_box_sphere: random and directed cube and
// sphere cull requests against several plane settings, checked by an exact predictor.
// Depends on fcbs_pkg and the frustum_cull_box_sphere RTL.

module tb_frustum_cull_box_sphere;

    import fcbs_pkg::*;

    localparam int PLANE_COUNT    = 6;
    localparam int MAX_IDLE       = 18;
    localparam int PIPE_SETTLE    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 10;
    localparam int BATCH_LEN      = 52;
    localparam int FULL_SPAN      = 32767;
    localparam int OFS_MAX        = (1 << (OFS_W - 1)) - 1;
    localparam int OFS_MIN        = -(1 << (OFS_W - 1));
    localparam int COEF_MAX       = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_MIN       = -(1 << (COEF_W - 1));
    localparam int UNIT           = 1 << FRAC_SHIFT;

    localparam logic CMD_CUBE   = 1'b0;
    localparam logic CMD_SPHERE = 1'b1;

    typedef enum int {
        STYLE_LATTICE,
        STYLE_BOX,
        STYLE_RANDOM,
        STYLE_SPARSE,
        STYLE_EXTREME
    } plane_style_t;

    typedef struct packed {
        logic                    command;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic signed [POS_W-1:0] cz;
        logic [EXT_W-1:0]        ext;
    } cull_req_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                    in_valid  = 1'b0;
    logic                    command   = CMD_CUBE;
    logic signed [POS_W-1:0] center_x  = '0;
    logic signed [POS_W-1:0] center_y  = '0;
    logic signed [POS_W-1:0] center_z  = '0;
    logic [EXT_W-1:0]        extent    = '0;
    logic                    out_ready = 1'b0;
    logic                    psel      = 1'b0;
    logic                    penable   = 1'b0;
    logic                    pwrite    = 1'b0;
    logic [ADDR_W-1:0]       paddr     = '0;
    logic [DATA_W-1:0]       pwdata    = '0;

    wire                     in_ready;
    wire                     out_valid;
    wire                     visible;
    wire [DATA_W-1:0]        prdata;
    wire                     pready;

    // Plane registers as the block should hold them
    plane_t    plane_shadow [REG_COUNT] = '{default: '0};
    cull_req_t pending_reqs [$];
    bit        visible_expected_q [$];

    int send_wait      = 0;
    int recv_wait      = 0;
    int idle_cycles    = 0;
    int mismatch_count = 0;
    bit send_idle_on   = 1'b1;
    bit recv_idle_on   = 1'b1;

    frustum_cull_box_sphere #(
        .NUM_PLANES (PLANE_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .center_x  (center_x),
        .center_y  (center_y),
        .center_z  (center_z),
        .extent    (extent),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .visible   (visible),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Exact visibility of a cube or sphere against the configured planes
    function automatic bit predict_visible(input logic cmd,
                                           input logic signed [POS_W-1:0] x,
                                           input logic signed [POS_W-1:0] y,
                                           input logic signed [POS_W-1:0] z,
                                           input logic [EXT_W-1:0] e);
        plane_t p;
        longint ca;
        longint cb;
        longint cc;
        longint plane_dist;
        longint reach;
        bit     vis;
        vis = 1'b1;
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            p    = plane_shadow[i];
            ca   = p.a;
            cb   = p.b;
            cc   = p.c;
            plane_dist = ca * longint'(x) + cb * longint'(y) + cc * longint'(z)
                       + longint'(p.d);
            if (cmd == CMD_SPHERE)
            begin
                if (plane_dist < -(longint'(e) * UNIT))
                    vis = 1'b0;
            end
            else
            begin
                // farthest corner along the normal
                reach = longint'(e) * ((ca < 0 ? -ca : ca) + (cb < 0 ? -cb : cb)
                                       + (cc < 0 ? -cc : cc));
                if (plane_dist + reach < 0)
                    vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic logic [DATA_W-1:0] pack_plane(input int a, input int b,
                                                     input int c, input int d);
        plane_t p;
        p.a = a[COEF_W-1:0];
        p.b = b[COEF_W-1:0];
        p.c = c[COEF_W-1:0];
        p.d = d[OFS_W-1:0];
        return p;
    endfunction

    function automatic void queue_req(input logic cmd, input int x, input int y,
                                      input int z, input int e);
        cull_req_t req;
        req.command = cmd;
        req.cx      = POS_W'(x);
        req.cy      = POS_W'(y);
        req.cz      = POS_W'(z);
        req.ext     = EXT_W'(e);
        pending_reqs.push_back(req);
    endfunction

    function automatic int rand_coord(input int span);
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            case ($urandom_range(0, 3))
                0: return -32768;
                1: return 32767;
                2: return 0;
                default: return -1;
            endcase
        end
        else if (sel < 4)
            return int'($urandom);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int rand_extent(input int span);
        case ($urandom_range(0, 15))
            0: return 0;
            1: return FULL_SPAN;
            2, 3, 4: return int'($urandom_range(0, FULL_SPAN));
            default: return int'($urandom_range(0, span));
        endcase
    endfunction

    // Setup then access phase; the register takes the data at the access edge
    task automatic write_plane(input int idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx_t'(idx), {IDX_LSB{1'b0}}};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < REG_COUNT)
            plane_shadow[idx] = value;
    endtask

    // Hold until every queued request is out and its result is back, then let the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || visible_expected_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    // Drive requests: hold each until accepted, then idle for the drawn gap
    always @(posedge clk)
    begin : drive_requests
        cull_req_t req;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                visible_expected_q.push_back(
                    predict_visible(command, center_x, center_y, center_z, extent));
            if (!in_valid || in_ready)
            begin
                if (send_wait != 0)
                begin
                    in_valid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req = pending_reqs.pop_front();
                    command   <= req.command;
                    center_x  <= req.cx;
                    center_y  <= req.cy;
                    center_z  <= req.cz;
                    extent    <= req.ext;
                    in_valid  <= 1'b1;
                    send_wait <= send_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check each result against the oldest prediction, then stall for the drawn count
    always @(posedge clk)
    begin : check_results
        int stall;
        bit want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (visible_expected_q.size() == 0)
                begin
                    $error("visible: unexpected result, expected none, got %0b", visible);
                    mismatch_count++;
                end
                else
                begin
                    want = visible_expected_q.pop_front();
                    if (visible !== want)
                    begin
                        $error("visible mismatch: expected %0b, got %0b", want, visible);
                        mismatch_count++;
                    end
                end
                stall = recv_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
                out_ready <= (stall == 0);
                recv_wait <= stall;
            end
            else if (recv_wait != 0)
            begin
                recv_wait <= recv_wait - 1;
                out_ready <= (recv_wait == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Abort when neither side moves for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        plane_style_t      style;
        logic [DATA_W-1:0] plane_val [REG_COUNT];
        int                box_half;
        int                coord_span;
        int                ext_span;
        int                axis;
        int                coef [3];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Planes at reset are all zero: nothing is rejected
        queue_req(CMD_CUBE, -32768, -32768, -32768, 0);
        queue_req(CMD_SPHERE, 32767, 32767, 32767, FULL_SPAN);
        wait_drained();

        // Single plane x >= 0: corner exactly on the plane and sphere touching it
        write_plane(0, pack_plane(UNIT, 0, 0, 0));
        for (int i = 1; i < REG_COUNT; i++)
            write_plane(i, '0);
        queue_req(CMD_CUBE, -16, 0, 0, 16);
        queue_req(CMD_CUBE, -17, 0, 0, 16);
        queue_req(CMD_SPHERE, -16, 0, 0, 16);
        queue_req(CMD_SPHERE, -17, 0, 0, 16);
        queue_req(CMD_CUBE, 0, 0, 0, 0);
        queue_req(CMD_CUBE, -1, 0, 0, 0);
        queue_req(CMD_SPHERE, 0, 0, 0, 0);
        queue_req(CMD_SPHERE, -1, 0, 0, 0);
        wait_drained();

        // Extreme coefficients and offsets; writes past the last plane are dropped
        write_plane(0, pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, OFS_MIN));
        write_plane(1, pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, OFS_MAX));
        write_plane(2, '1);
        write_plane(3, '0);
        write_plane(4, pack_plane(COEF_MAX, 0, COEF_MIN, 0));
        write_plane(5, pack_plane(0, -1, 1, OFS_MAX));
        write_plane(REG_COUNT, '1);
        write_plane(REG_COUNT + 1, pack_plane(COEF_MIN, COEF_MAX, 1, OFS_MIN));
        for (int s = 0; s < 2; s++)
            for (int e = 0; e < 2; e++)
            begin
                queue_req(CMD_CUBE, s ? 32767 : -32768, s ? 32767 : -32768,
                          s ? 32767 : -32768, e ? FULL_SPAN : 0);
                queue_req(CMD_SPHERE, s ? 32767 : -32768, s ? 32767 : -32768,
                          s ? 32767 : -32768, e ? FULL_SPAN : 0);
            end
        queue_req(CMD_CUBE, 32767, -32768, 32767, FULL_SPAN);
        queue_req(CMD_SPHERE, -32768, 32767, -32768, FULL_SPAN);
        queue_req(CMD_CUBE, -32768, 32767, 0, 1);
        queue_req(CMD_SPHERE, 32767, -32768, 0, 1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            style        = plane_style_t'(ph % 5);
            send_idle_on = (ph % 3 != 1);
            recv_idle_on = (ph % 4 != 1);
            coord_span   = FULL_SPAN;
            ext_span     = FULL_SPAN;
            box_half     = $urandom_range(16, 12000);
            for (int i = 0; i < REG_COUNT; i++)
            begin
                case (style)
                    STYLE_LATTICE:
                    begin
                        // whole-unit normals and offsets: boundary ties are common
                        for (int k = 0; k < 3; k++)
                            coef[k] = UNIT * (int'($urandom_range(0, 3)) - 2);
                        plane_val[i] = pack_plane(coef[0], coef[1], coef[2],
                                                  UNIT * (int'($urandom_range(0, 128)) - 64));
                    end
                    STYLE_BOX:
                    begin
                        // axis-aligned box of half-size box_half around the origin
                        axis = i / 2;
                        for (int k = 0; k < 3; k++)
                            coef[k] = (k == axis) ? ((i % 2) ? -UNIT : UNIT) : 0;
                        plane_val[i] = pack_plane(coef[0], coef[1], coef[2], UNIT * box_half);
                    end
                    STYLE_RANDOM:
                        plane_val[i] = {$urandom, $urandom};
                    STYLE_SPARSE:
                    begin
                        if ($urandom_range(0, 1))
                            plane_val[i] = '0;
                        else
                            plane_val[i] = pack_plane(int'($urandom) >>> 20,
                                                      int'($urandom) >>> 20,
                                                      int'($urandom) >>> 20,
                                                      int'($urandom) >>> (4 + $urandom_range(0, 16)));
                    end
                    default:
                    begin
                        case ($urandom_range(0, 4))
                            0: plane_val[i] = '0;
                            1: plane_val[i] = '1;
                            2: plane_val[i] = pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, OFS_MAX);
                            3: plane_val[i] = pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, OFS_MIN);
                            default: plane_val[i] = pack_plane(COEF_MAX, COEF_MIN, COEF_MAX,
                                                               OFS_MIN);
                        endcase
                    end
                endcase
            end
            if (style == STYLE_LATTICE)
            begin
                coord_span = 64;
                ext_span   = 64;
            end
            else if (style == STYLE_BOX)
            begin
                coord_span = 2 * box_half;
                ext_span   = (box_half / 2 > 0) ? box_half / 2 : 1;
            end
            for (int i = 0; i < REG_COUNT; i++)
                write_plane(i, plane_val[i]);

            // two batches; the sender holds between them until all results are back
            for (int half = 0; half < 2; half++)
            begin
                for (int n = 0; n < BATCH_LEN; n++)
                    queue_req(logic'($urandom_range(0, 1)), rand_coord(coord_span),
                              rand_coord(coord_span), rand_coord(coord_span),
                              rand_extent(ext_span));
                wait_drained();
            end
        end

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
